// ===== sv/ffa_pkg.sv =====
// Package for the first-fit free-list allocator.
// Holds the arena constants, header word type and the controller/datapath command types.
// No dependencies.
`default_nettype none
package ffa_pkg;

    localparam int ARENA_UNITS = 1024;
    localparam int UNIT_BYTES  = 8;
    localparam int UB_SHIFT    = $clog2(UNIT_BYTES);
    localparam int AW          = $clog2(ARENA_UNITS);
    localparam int SW          = AW + 1;
    localparam int NW          = AW + 2;
    localparam int STW         = AW + 1;
    localparam int BYTES_W     = 14;

    typedef struct packed {
        logic [SW-1:0] size;
        logic [AW-1:0] next;
    } t_word;

    typedef enum logic [2:0] {
        A_ROVER, A_QNEXT, A_PREV, A_BP, A_NX, A_P, A_TAIL
    } t_asel;

    typedef enum logic [2:0] {
        W_CLR, W_SHRINK, W_EXACT, W_NEWHDR, W_BPMERGE, W_PMERGE
    } t_wsel;

    typedef enum logic [1:0] {
        R_FAIL, R_EXACT, R_SPLIT, R_FREE
    } t_rsel;

    typedef struct packed {
        logic  ld_req;
        logic  rd_en;
        t_asel rd_sel;
        logic  wr_en;
        t_wsel wr_sel;
        logic  set_prev_rover;
        logic  set_p_rover;
        logic  set_p_qnext;
        logic  step_alloc;
        logic  step_free;
        logic  save_pw;
        logic  save_nx;
        logic  save_bpw;
        logic  rover_prev;
        logic  rover_p;
        logic  res_ld;
        t_rsel res_sel;
        logic  clr_step;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic bad_idx;
        logic fits;
        logic exact;
        logic p_is_rover;
        logic steps_end;
        logic found;
        logic clr_last;
        logic out_full;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/first_fit_free_list_allocator_top.sv =====
// Top level of the first-fit free-list allocator.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp.
`default_nettype none
// First-fit allocator over a 1024-unit arena of 8-byte units, with a circular,
// address-ordered free list kept in a single-port header store (one access per cycle).
// After reset the store is initialized by a clearing pass during which no transfer
// is taken. An allocate walks from the rover to the first block that fits, unlinks an
// exact fit or carves off its tail; a free walks to its place and links the block in,
// merging adjacent free blocks; an illegal free index returns without a walk. The list
// walk reads one header per cycle. One item is in work at a time, and the result
// register lets the next item in once its result has been transferred.
module first_fit_free_list_allocator_top import ffa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_func,
    input  wire logic [BYTES_W-1:0] i_size_bytes,
    input  wire logic [AW-1:0]      i_block_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [AW-1:0]           o_data_index,
    output logic                    o_ok
);

    t_cmd cmd;
    t_sts sts;

    ffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ffa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_size_bytes  (i_size_bytes),
        .i_block_index (i_block_index),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_data_index  (o_data_index),
        .o_ok          (o_ok)
    );

endmodule
`default_nettype wire

// ===== sv/ffa_dp.sv =====
// Datapath of the allocator: header store, list pointers, arithmetic and result register.
// Depends on ffa_pkg; driven by ffa_ctrl through t_cmd.
`default_nettype none
module ffa_dp import ffa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_func,
    input  wire logic [BYTES_W-1:0] i_size_bytes,
    input  wire logic [AW-1:0]      i_block_index,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [AW-1:0]           o_data_index,
    output logic                    o_ok
);

    t_word mem [ARENA_UNITS];

    t_word          r_q, r_pw, r_bpw, wdata;
    logic           r_func, r_bad;
    logic [NW-1:0]  r_need, r_tail, n_need;
    logic [AW-1:0]  r_bp, r_p, r_prev, r_nx, r_rover, r_clr, raddr, waddr;
    logic [STW-1:0] r_steps;
    logic           r_ovalid, r_ok, wr_ok;
    logic [AW-1:0]  r_odata;
    logic [BYTES_W:0] units_raw;
    logic [NW-1:0]  units;

    // Byte count rounded up to whole units, at least one, plus the header unit.
    always_comb begin
        units_raw = ({1'b0, i_size_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1)) >> UB_SHIFT;
        units     = NW'(units_raw);
        if (units == '0) begin
            units = NW'(1);
        end
        n_need = units + NW'(1);
    end

    always_comb begin
        case (i_cmd.rd_sel)
            A_ROVER: raddr = r_rover;
            A_QNEXT: raddr = r_q.next;
            A_PREV:  raddr = r_prev;
            A_BP:    raddr = r_bp;
            A_NX:    raddr = r_nx;
            A_P:     raddr = r_p;
            A_TAIL:  raddr = r_tail[AW-1:0];
            default: raddr = r_p;
        endcase
    end

    always_comb begin
        wr_ok = 1'b1;
        case (i_cmd.wr_sel)
            W_CLR: begin
                waddr = r_clr;
                if (r_clr == AW'(0)) begin
                    wdata = '{size: SW'(1), next: AW'(1)};
                end else if (r_clr == AW'(1)) begin
                    wdata = '{size: SW'(ARENA_UNITS - 1), next: '0};
                end else begin
                    wdata = '0;
                end
            end
            W_SHRINK: begin
                waddr = r_p;
                wdata = '{size: r_q.size - SW'(r_need), next: r_q.next};
            end
            W_EXACT: begin
                waddr = r_prev;
                wdata = '{size: r_q.size, next: r_pw.next};
            end
            W_NEWHDR: begin
                // The carved tail may lie past the arena only on a corrupted list.
                waddr = r_tail[AW-1:0];
                wdata = '{size: SW'(r_need), next: r_q.next};
                wr_ok = r_tail < NW'(ARENA_UNITS);
            end
            W_BPMERGE: begin
                waddr = r_bp;
                if (NW'(r_bp) + NW'(r_bpw.size) == NW'(r_nx)) begin
                    wdata = '{size: r_bpw.size + r_q.size, next: r_q.next};
                end else begin
                    wdata = '{size: r_bpw.size, next: r_nx};
                end
            end
            W_PMERGE: begin
                waddr = r_p;
                if (NW'(r_p) + NW'(r_pw.size) == NW'(r_bp)) begin
                    wdata = '{size: r_pw.size + r_q.size, next: r_q.next};
                end else begin
                    wdata = '{size: r_pw.size, next: r_bp};
                end
            end
            default: begin
                waddr = r_p;
                wdata = '0;
                wr_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_ok) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_q <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_func <= i_func;
            r_need <= n_need;
            r_bp   <= i_block_index - AW'(1);
            r_bad  <= (i_block_index <= AW'(1))
                      || ({1'b0, i_block_index} >= (AW+1)'(ARENA_UNITS));
        end
        if (i_cmd.set_prev_rover) begin
            r_prev <= r_rover;
        end
        if (i_cmd.set_p_rover) begin
            r_p <= r_rover;
        end
        if (i_cmd.set_p_qnext || i_cmd.step_free) begin
            r_p <= r_q.next;
        end
        if (i_cmd.step_alloc) begin
            r_prev <= r_p;
            r_p    <= r_q.next;
        end
        if (i_cmd.save_pw) begin
            r_pw   <= r_q;
            r_tail <= NW'(r_p) + NW'(r_q.size) - r_need;
        end
        if (i_cmd.save_nx) begin
            r_nx <= r_q.next;
        end
        if (i_cmd.save_bpw) begin
            r_bpw <= r_q;
        end
        if (i_cmd.res_ld) begin
            case (i_cmd.res_sel)
                R_EXACT: begin
                    r_odata <= r_p + AW'(1);
                    r_ok    <= 1'b1;
                end
                R_SPLIT: begin
                    r_odata <= r_tail[AW-1:0] + AW'(1);
                    r_ok    <= 1'b1;
                end
                R_FREE: begin
                    r_odata <= '0;
                    r_ok    <= 1'b1;
                end
                default: begin
                    r_odata <= '0;
                    r_ok    <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover  <= '0;
            r_clr    <= '0;
            r_steps  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.set_p_rover || i_cmd.set_p_qnext) begin
                r_steps <= '0;
            end else if (i_cmd.step_alloc || i_cmd.step_free) begin
                r_steps <= r_steps + STW'(1);
            end
            if (i_cmd.rover_prev) begin
                r_rover <= r_prev;
            end else if (i_cmd.rover_p) begin
                r_rover <= r_p;
            end
            if (i_cmd.res_ld) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.is_free    = r_func;
        o_sts.bad_idx    = r_bad;
        o_sts.fits       = NW'(r_q.size) >= r_need;
        o_sts.exact      = NW'(r_q.size) == r_need;
        o_sts.p_is_rover = r_p == r_rover;
        o_sts.steps_end  = r_steps == STW'(ARENA_UNITS);
        o_sts.found      = (r_bp > r_p && r_bp < r_q.next)
                           || (r_p >= r_q.next && (r_bp > r_p || r_bp < r_q.next));
        o_sts.clr_last   = r_clr == AW'(ARENA_UNITS - 1);
        o_sts.out_full   = r_ovalid;
    end

    assign o_valid      = r_ovalid;
    assign o_data_index = r_odata;
    assign o_ok         = r_ok;

endmodule
`default_nettype wire

// ===== sv/ffa_ctrl.sv =====
// Controller of the allocator: sequences store clearing, list walks and header updates.
// Depends on ffa_pkg; commands ffa_dp through t_cmd and reads back t_sts.
`default_nettype none
module ffa_ctrl import ffa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [14:0] {
        S_CLEAR   = 15'b000000000000001,
        S_IDLE    = 15'b000000000000010,
        S_DISP    = 15'b000000000000100,
        S_A_LD0   = 15'b000000000001000,
        S_A_CHK   = 15'b000000000010000,
        S_A_EX_WR = 15'b000000000100000,
        S_A_SP_RD = 15'b000000001000000,
        S_A_SP_WR = 15'b000000010000000,
        S_F_CHK   = 15'b000000100000000,
        S_F_BP    = 15'b000001000000000,
        S_F_NX    = 15'b000010000000000,
        S_F_RDP   = 15'b000100000000000,
        S_F_RDBP  = 15'b001000000000000,
        S_F_WRP   = 15'b010000000000000,
        S_SPARE   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   take;

    assign take    = (r_state == S_IDLE) && !i_sts.out_full;
    assign o_stall = !take;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = W_CLR;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take && i_valid) begin
                    o_cmd.ld_req = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_free && i_sts.bad_idx) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = R_FAIL;
                    n_state       = S_IDLE;
                end else if (i_sts.is_free) begin
                    o_cmd.set_p_rover = 1'b1;
                    o_cmd.rd_en       = 1'b1;
                    o_cmd.rd_sel      = A_ROVER;
                    n_state           = S_F_CHK;
                end else begin
                    o_cmd.set_prev_rover = 1'b1;
                    o_cmd.rd_en          = 1'b1;
                    o_cmd.rd_sel         = A_ROVER;
                    n_state              = S_A_LD0;
                end
            end
            S_A_LD0: begin
                o_cmd.set_p_qnext = 1'b1;
                o_cmd.rd_en       = 1'b1;
                o_cmd.rd_sel      = A_QNEXT;
                n_state           = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_sts.fits) begin
                    o_cmd.save_pw = 1'b1;
                    if (i_sts.exact) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = A_PREV;
                        n_state      = S_A_EX_WR;
                    end else begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = W_SHRINK;
                        n_state      = S_A_SP_RD;
                    end
                end else if (i_sts.p_is_rover || i_sts.steps_end) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = R_FAIL;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.step_alloc = 1'b1;
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.rd_sel     = A_QNEXT;
                end
            end
            S_A_EX_WR: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_sel     = W_EXACT;
                o_cmd.rover_prev = 1'b1;
                o_cmd.res_ld     = 1'b1;
                o_cmd.res_sel    = R_EXACT;
                n_state          = S_IDLE;
            end
            S_A_SP_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = A_TAIL;
                n_state      = S_A_SP_WR;
            end
            S_A_SP_WR: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_sel     = W_NEWHDR;
                o_cmd.rover_prev = 1'b1;
                o_cmd.res_ld     = 1'b1;
                o_cmd.res_sel    = R_SPLIT;
                n_state          = S_IDLE;
            end
            S_F_CHK: begin
                if (i_sts.found) begin
                    o_cmd.save_nx = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = A_BP;
                    n_state       = S_F_BP;
                end else if (i_sts.steps_end) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = R_FAIL;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.step_free = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = A_QNEXT;
                end
            end
            S_F_BP: begin
                o_cmd.save_bpw = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = A_NX;
                n_state        = S_F_NX;
            end
            S_F_NX: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = W_BPMERGE;
                n_state      = S_F_RDP;
            end
            S_F_RDP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = A_P;
                n_state      = S_F_RDBP;
            end
            S_F_RDBP: begin
                o_cmd.save_pw = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = A_BP;
                n_state       = S_F_WRP;
            end
            S_F_WRP: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = W_PMERGE;
                o_cmd.rover_p = 1'b1;
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_sel = R_FREE;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== tb/first_fit_free_list_allocator_top_tb.sv =====
// Self-checking testbench for the first-fit free-list allocator top level.
// A generator predicts each result from its own model of the header store and free list.
// Depends on ffa_pkg and first_fit_free_list_allocator_top.
`timescale 1ns / 1ps
module first_fit_free_list_allocator_top_tb;
    import ffa_pkg::*;

    localparam int N_RANDOM   = 480;
    localparam int QUIET_TAIL = 50;
    localparam int IDLE_LIMIT = 8000;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct {
        logic               func;
        logic [BYTES_W-1:0] size_bytes;
        logic [AW-1:0]      block_index;
        bit                 wait_drain;
    } t_request;

    typedef struct {
        logic [AW-1:0] data_index;
        logic          ok;
    } t_grant;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_func = 1'b0;
    logic [BYTES_W-1:0] i_size_bytes = '0;
    logic [AW-1:0]      i_block_index = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [AW-1:0]      o_data_index;
    logic               o_ok;

    first_fit_free_list_allocator_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_size_bytes(i_size_bytes), .i_block_index(i_block_index),
        .o_valid(o_valid), .i_stall(i_stall), .o_data_index(o_data_index), .o_ok(o_ok)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the header store and search pointer.
    int unsigned hdr_size[ARENA_UNITS];
    int unsigned hdr_next[ARENA_UNITS];
    int unsigned search_start;

    t_request    pending_q[$];
    t_grant      grant_q[$];
    int unsigned live_blocks[$];
    int          n_total = 0;
    int          n_sent = 0;
    int          n_recv = 0;
    int          n_errors = 0;

    function automatic int unsigned get_size(int unsigned i);
        return i < ARENA_UNITS ? hdr_size[i] : 0;
    endfunction

    function automatic int unsigned get_next(int unsigned i);
        return i < ARENA_UNITS ? hdr_next[i] : 0;
    endfunction

    function automatic void put_size(int unsigned i, int unsigned v);
        if (i < ARENA_UNITS) hdr_size[i] = v;
    endfunction

    function automatic void put_next(int unsigned i, int unsigned v);
        if (i < ARENA_UNITS) hdr_next[i] = v;
    endfunction

    function automatic t_grant first_fit_alloc(int unsigned bytes);
        t_grant      g;
        int unsigned units, need, prev, p, sz;
        g.data_index = '0;
        g.ok = 1'b0;
        units = (bytes + UNIT_BYTES - 1) / UNIT_BYTES;
        if (units == 0) units = 1;
        need = units + 1;
        prev = search_start;
        p = get_next(prev);
        for (int steps = 0; steps <= ARENA_UNITS; steps++) begin
            sz = get_size(p);
            if (sz >= need) begin
                if (sz == need) begin
                    put_next(prev, get_next(p));
                end else begin
                    put_size(p, sz - need);
                    p = p + (sz - need);
                    put_size(p, need);
                end
                search_start = prev;
                g.data_index = AW'(p + 1);
                g.ok = 1'b1;
                return g;
            end
            if (p == search_start) break;
            prev = p;
            p = get_next(p);
        end
        return g;
    endfunction

    function automatic t_grant release_block(int unsigned idx);
        t_grant      g;
        int unsigned bp, p, nx;
        bit          found;
        g.data_index = '0;
        g.ok = 1'b0;
        found = 0;
        if (idx <= 1 || idx >= ARENA_UNITS) return g;
        bp = idx - 1;
        p = search_start;
        for (int steps = 0; steps <= ARENA_UNITS; steps++) begin
            nx = get_next(p);
            if (bp > p && bp < nx) begin
                found = 1;
                break;
            end
            if (p >= nx && (bp > p || bp < nx)) begin
                found = 1;
                break;
            end
            p = nx;
        end
        if (!found) return g;
        nx = get_next(p);
        if (bp + get_size(bp) == nx) begin
            put_size(bp, get_size(bp) + get_size(nx));
            put_next(bp, get_next(nx));
        end else begin
            put_next(bp, nx);
        end
        if (p + get_size(p) == bp) begin
            put_size(p, get_size(p) + get_size(bp));
            put_next(p, get_next(bp));
        end else begin
            put_next(p, bp);
        end
        search_start = p;
        g.ok = 1'b1;
        return g;
    endfunction

    task automatic add_request(logic func, int unsigned bytes, int unsigned idx,
                               bit wait_drain = 0);
        t_request r;
        t_grant   g;
        r.func = func;
        r.size_bytes = BYTES_W'(bytes);
        r.block_index = AW'(idx);
        r.wait_drain = wait_drain;
        if (func == OP_ALLOC) begin
            g = first_fit_alloc(32'(r.size_bytes));
            if (g.ok) live_blocks.push_back(32'(g.data_index));
        end else begin
            g = release_block(32'(r.block_index));
        end
        pending_q.push_back(r);
        grant_q.push_back(g);
        n_total++;
    endtask

    task automatic free_live(bit wait_drain = 0);
        int k;
        k = $urandom_range(0, live_blocks.size() - 1);
        add_request(OP_FREE, $urandom, live_blocks[k], wait_drain);
        live_blocks.delete(k);
    endtask

    // Driver: holds the payload while stalled, otherwise picks the next request or a gap.
    int drv_gap = 0;
    always @(posedge i_clk) begin
        bit       take;
        t_request r;
        take = i_valid && !o_stall;
        if (take) n_sent <= n_sent + 1;
        if (i_rst_n && !(i_valid && !take)) begin
            if (drv_gap > 0) begin
                drv_gap = drv_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0 && !(pending_q[0].wait_drain
                         && (n_sent + take) != n_recv)) begin
                if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                    drv_gap = $urandom_range(0, 13);
                    i_valid <= 1'b0;
                end else begin
                    r = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_func <= r.func;
                    i_size_bytes <= r.size_bytes;
                    i_block_index <= r.block_index;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer and drives the output stall.
    int  mon_burst = 0;
    int  mon_hold = 0;
    bit  hold_done = 0;
    always @(posedge i_clk) begin
        t_grant g;
        bit     nxt;
        if (o_valid && !i_stall && i_rst_n) begin
            n_recv <= n_recv + 1;
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected result data_index=%0d ok=%0b",
                         $time, o_data_index, o_ok);
                n_errors++;
            end else begin
                g = grant_q.pop_front();
                if (o_data_index !== g.data_index) begin
                    $display("%0t: data_index expected %0d actual %0d",
                             $time, g.data_index, o_data_index);
                    n_errors++;
                end
                if (o_ok !== g.ok) begin
                    $display("%0t: ok expected %0b actual %0b", $time, g.ok, o_ok);
                    n_errors++;
                end
            end
        end
        if (mon_hold > 0) begin
            mon_hold = mon_hold - 1;
            nxt = 1;
        end else if (!hold_done && n_recv >= 100) begin
            // Long hold-off so the input side backs up and stalls.
            hold_done = 1;
            mon_hold = 300;
            nxt = 1;
        end else if (mon_burst > 0) begin
            mon_burst = mon_burst - 1;
            nxt = 1;
        end else if (n_recv < n_total - QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            mon_burst = $urandom_range(0, 13);
            nxt = 1;
        end else begin
            nxt = 0;
        end
        i_stall <= nxt;
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("** first_fit_free_list_allocator_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sel;
        for (int i = 0; i < ARENA_UNITS; i++) begin
            hdr_size[i] = 0;
            hdr_next[i] = 0;
        end
        hdr_size[0] = 1;
        hdr_next[0] = 1;
        hdr_size[1] = ARENA_UNITS - 1;
        search_start = 0;

        // Directed: whole-arena exact fit, oversize, zero and boundary sizes, bad indexes.
        add_request(OP_ALLOC, 8176, 0);
        add_request(OP_ALLOC, 8, 0);
        free_live();
        add_request(OP_ALLOC, 8192, 0);
        add_request(OP_ALLOC, 0, 1023);
        add_request(OP_ALLOC, 1, 0);
        add_request(OP_ALLOC, 8, 0);
        add_request(OP_ALLOC, 9, 0);
        add_request(OP_ALLOC, 16383 & 8191, 0);
        add_request(OP_FREE, 0, 0);
        add_request(OP_FREE, 0, 1);
        free_live();
        free_live();
        add_request(OP_ALLOC, 16, 0);
        free_live();
        free_live();
        free_live();
        add_request(OP_ALLOC, 4000, 0);
        add_request(OP_ALLOC, 4000, 0, 1);
        add_request(OP_FREE, 16383, 1023);
        while (live_blocks.size() > 0) free_live();

        for (int i = 0; i < N_RANDOM; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                // Noise: sizes up to 8192 bytes, any index, including double and stray frees.
                add_request(1'($urandom), $urandom_range(0, 8192), $urandom);
            end else if (sel < 45 && live_blocks.size() > 0) begin
                free_live(i % 97 == 50);
            end else if (sel < 48) begin
                add_request(OP_ALLOC, $urandom_range(1024, 8192), $urandom);
            end else begin
                add_request(OP_ALLOC, $urandom_range(0, 240), $urandom);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && n_recv == n_total);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && grant_q.size() == 0) begin
            $display("** first_fit_free_list_allocator_top: PASSED **");
        end else begin
            $display("%0t: %0d mismatches, %0d results missing", $time, n_errors,
                     grant_q.size());
            $display("** first_fit_free_list_allocator_top: FAILED **");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/ffa_pkg.sv
sv/ffa_dp.sv
sv/ffa_ctrl.sv
sv/first_fit_free_list_allocator_top.sv
tb/first_fit_free_list_allocator_top_tb.sv
